### hw/rtl/som_pkg.sv
// ----------------------------------------------------------------------------
// som_pkg: shared definitions of the length-prefixed frame deframer
// Result kinds, register indexes, reply constants and the result record
// passed from the frame tracker to the output stage.
// ----------------------------------------------------------------------------
package som_pkg;

   localparam logic [1:0] KIND_TEXT    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_REPLY   = 2'd2;

   localparam logic CSR_START_BYTE = 1'b0;
   localparam logic CSR_NACK_CODE  = 1'b1;

   localparam logic [7:0] START_BYTE_RESET = 8'd2;
   localparam logic [7:0] NACK_CODE_RESET  = 8'd78;

   localparam logic [7:0] REPLY_LEN_BYTE = 8'd2;
   localparam logic [2:0] REPLY_BEATS    = 3'd4;

   localparam logic [1:0] REPLY_POS_START = 2'd0;
   localparam logic [1:0] REPLY_POS_LEN   = 2'd1;
   localparam logic [1:0] REPLY_POS_CODE  = 2'd2;
   localparam logic [1:0] REPLY_POS_SUM   = 2'd3;

   typedef struct packed {
      logic       emit;
      logic       nack;
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] index;
      logic       frame_end;
      logic       good;
      logic       last;
   } som_result_type;

endpackage

### hw/rtl/som_frame_tracker.sv
// ----------------------------------------------------------------------------
// som_frame_tracker: frame state and checksum accumulator
// Tracks the frame phase, length, byte count and running sum, and forms the
// result of the current received byte combinationally.
// ----------------------------------------------------------------------------
module som_frame_tracker
   import som_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     rx_byte,
   input  logic [7:0]     start_byte,
   output som_result_type result
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_WAIT_LEN = 2'd1,
      PH_WAIT_END = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] sum_add;
   logic [7:0] count_add;

   assign sum_add   = sum_ff + rx_byte;
   assign count_add = count_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      length_in = length_ff;
      result    = '0;
      unique case (phase_ff)
         PH_WAIT_LEN: begin
            length_in = rx_byte;
            count_in  = '0;
            sum_in    = sum_add;
            phase_in  = PH_WAIT_END;
         end
         PH_WAIT_END: begin
            count_in     = count_add;
            sum_in       = sum_add;
            result.emit  = 1'b1;
            result.kind  = KIND_PAYLOAD;
            result.data  = rx_byte;
            result.index = count_ff;
            result.last  = 1'b1;
            if (count_add == length_ff) begin
               phase_in         = PH_IDLE;
               result.frame_end = 1'b1;
               result.good      = (sum_add == 8'd0);
               result.last      = (sum_add == 8'd0);
               result.nack      = (sum_add != 8'd0);
            end
         end
         default: begin
            if (rx_byte == start_byte) begin
               phase_in = PH_WAIT_LEN;
               sum_in   = '0;
            end else begin
               phase_in     = PH_IDLE;
               result.emit  = 1'b1;
               result.kind  = KIND_TEXT;
               result.data  = rx_byte;
               result.last  = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         sum_ff    <= '0;
         count_ff  <= '0;
         length_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         length_ff <= length_in;
      end
   end

endmodule

### hw/rtl/som_length_checksum_deframer.sv
// ----------------------------------------------------------------------------
// som_length_checksum_deframer: length-prefixed zero-sum frame deframer
// Passes text bytes, streams frame payload bytes with their index and flags
// the frame end, and sends a four-beat NACK reply on a bad checksum.
// ----------------------------------------------------------------------------
// A received byte is taken in every cycle while the result register is free or
// draining and no reply is pending, so text and payload bytes run at one beat
// per cycle and each appears in the cycle after it is taken. The start and
// length bytes give no result beat. A frame that ends with a bad sum gives five
// result beats, and the input stalls while the reply sequencer sends the reply.
module som_length_checksum_deframer
   import som_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_payload_index,
   output logic       rsp_frame_end,
   output logic       rsp_checksum_good,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);

   logic           valid_ff, valid_in;
   som_result_type out_ff, out_in;
   logic [2:0]     left_ff, left_in;
   logic [7:0]     start_byte_ff;
   logic [7:0]     nack_code_ff;
   logic           accept;
   logic           slot_free;
   som_result_type result;
   som_result_type reply;
   logic [1:0]     reply_pos;

   assign slot_free = !valid_ff || !rsp_stall;
   assign req_stall = !slot_free || (left_ff != 3'd0);
   assign accept    = req_valid && !req_stall;

   som_frame_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .start_byte (start_byte_ff),
      .result     (result)
   );

   assign reply_pos = 2'(REPLY_BEATS - left_ff);

   always_comb begin
      reply      = '0;
      reply.emit = 1'b1;
      reply.kind = KIND_REPLY;
      unique case (reply_pos)
         REPLY_POS_START: reply.data = start_byte_ff;
         REPLY_POS_LEN:   reply.data = REPLY_LEN_BYTE;
         REPLY_POS_CODE:  reply.data = nack_code_ff;
         REPLY_POS_SUM: begin
            reply.data = 8'd0 - REPLY_LEN_BYTE - nack_code_ff;
            reply.last = 1'b1;
         end
         default: reply.data = start_byte_ff;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      left_in  = left_ff;
      priority if (accept && result.emit) begin
         valid_in = 1'b1;
         out_in   = result;
         if (result.nack) begin
            left_in = REPLY_BEATS;
         end
      end else if (slot_free && (left_ff != 3'd0)) begin
         valid_in = 1'b1;
         out_in   = reply;
         left_in  = left_ff - 3'd1;
      end else if (slot_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         left_ff       <= '0;
         start_byte_ff <= START_BYTE_RESET;
         nack_code_ff  <= NACK_CODE_RESET;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_START_BYTE: start_byte_ff <= csr_data;
               CSR_NACK_CODE:  nack_code_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_kind      = out_ff.kind;
   assign rsp_out_byte      = out_ff.data;
   assign rsp_payload_index = out_ff.index;
   assign rsp_frame_end     = out_ff.frame_end;
   assign rsp_checksum_good = out_ff.good;
   assign rsp_last          = out_ff.last;

   // A pending reply always has a beat waiting in the result register.
   a_reply_has_beat: assert property (@(posedge clock) disable iff (reset)
      (left_ff != 3'd0) |-> valid_ff)
      else $error("reply pending without a result beat");

   // No new byte is taken while the reply is being sent.
   a_reply_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (left_ff != 3'd0) |-> !accept)
      else $error("byte accepted during reply");

   // A bad frame end is never the last beat of its byte.
   a_bad_end_not_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_ff.frame_end && !out_ff.good) |-> !out_ff.last)
      else $error("bad frame end marked last");

   // The final reply beat leaves no reply pending.
   a_reply_last_done: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (out_ff.kind == KIND_REPLY) && out_ff.last) |-> (left_ff == 3'd0))
      else $error("reply ended early");

endmodule
